// ===== rtl/core/ebalu_pkg.sv =====
// ----------------------------------------------------------------------------
// ebalu_pkg
// Operation codes and transfer payload types for the eight-bit flag ALU.
// ----------------------------------------------------------------------------
package ebalu_pkg;

  localparam int OpW = 6;

  // operation codes
  localparam logic [OpW-1:0] OP_ADD   = 6'd0;
  localparam logic [OpW-1:0] OP_ADC   = 6'd1;
  localparam logic [OpW-1:0] OP_SUB   = 6'd2;
  localparam logic [OpW-1:0] OP_SBC   = 6'd3;
  localparam logic [OpW-1:0] OP_AND   = 6'd4;
  localparam logic [OpW-1:0] OP_XOR   = 6'd5;
  localparam logic [OpW-1:0] OP_OR    = 6'd6;
  localparam logic [OpW-1:0] OP_CP    = 6'd7;
  localparam logic [OpW-1:0] OP_INC8  = 6'd8;
  localparam logic [OpW-1:0] OP_DEC8  = 6'd9;
  localparam logic [OpW-1:0] OP_ADD16 = 6'd10;
  localparam logic [OpW-1:0] OP_INC16 = 6'd11;
  localparam logic [OpW-1:0] OP_DEC16 = 6'd12;
  localparam logic [OpW-1:0] OP_SPOFS = 6'd13;
  localparam logic [OpW-1:0] OP_DAA   = 6'd14;
  localparam logic [OpW-1:0] OP_CPL   = 6'd15;
  localparam logic [OpW-1:0] OP_SCF   = 6'd16;
  localparam logic [OpW-1:0] OP_CCF   = 6'd17;
  localparam logic [OpW-1:0] OP_RLCA  = 6'd18;
  localparam logic [OpW-1:0] OP_RRCA  = 6'd19;
  localparam logic [OpW-1:0] OP_RLA   = 6'd20;
  localparam logic [OpW-1:0] OP_RRA   = 6'd21;
  localparam logic [OpW-1:0] OP_RLC   = 6'd22;
  localparam logic [OpW-1:0] OP_RRC   = 6'd23;
  localparam logic [OpW-1:0] OP_RL    = 6'd24;
  localparam logic [OpW-1:0] OP_RR    = 6'd25;
  localparam logic [OpW-1:0] OP_SLA   = 6'd26;
  localparam logic [OpW-1:0] OP_SRA   = 6'd27;
  localparam logic [OpW-1:0] OP_SWAP  = 6'd28;
  localparam logic [OpW-1:0] OP_SRL   = 6'd29;
  localparam logic [OpW-1:0] OP_BIT   = 6'd30;
  localparam logic [OpW-1:0] OP_RES   = 6'd31;
  localparam logic [OpW-1:0] OP_SET   = 6'd32;

  // bcd adjust constants
  localparam logic [7:0] DAA_LO  = 8'h06;
  localparam logic [7:0] DAA_HI  = 8'h60;
  localparam logic [7:0] BCD_MAX = 8'h99;
  localparam logic [3:0] NIB_MAX = 4'h9;

  typedef struct packed {
    logic [OpW-1:0] req_type;
    logic [7:0]     acc;
    logic [7:0]     operand;
    logic [15:0]    wide_base;
    logic [15:0]    wide_operand;
    logic [2:0]     bit_index;
    logic           zero_in;
    logic           subtract_in;
    logic           half_carry_in;
    logic           carry_in;
  } alu_in_t;

  typedef struct packed {
    logic [15:0] result;
    logic        zero_out;
    logic        subtract_out;
    logic        half_carry_out;
    logic        carry_out;
  } alu_out_t;

endpackage

// ===== rtl/core/eight_bit_alu_with_flags_top.sv =====
// ----------------------------------------------------------------------------
// eight_bit_alu_with_flags_top
// Eight-bit ALU with Z/N/H/C flags, 16-bit add/inc/dec and SP offset.
// ----------------------------------------------------------------------------
// path: an item passes the input register, then the result register, before
//   out_valid rises for it
// throughput: one item per cycle while not stalled; two-entry pipeline (stage
//   one, result reg), so an item is taken while a result waits if s1 is empty
// reset: rst_n synchronous active low clears both stage valids; payload
//   registers are not reset
module eight_bit_alu_with_flags_top
  import ebalu_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  alu_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output alu_out_t out_data
);

  alu_in_t  s1_r;
  logic     s1_valid_r;
  alu_out_t out_r;
  logic     out_valid_r;
  alu_out_t res_nxt;
  logic     s2_en;
  logic     s1_ld;

  // pipeline advance
  assign s2_en    = !out_valid_r || !out_stall;
  assign s1_ld    = !s1_valid_r || s2_en;
  assign in_stall = !s1_ld;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ld) begin
      s1_valid_r <= in_valid;
    end
    if (s1_ld && in_valid) begin
      s1_r <= in_data;
    end
  end

  // datapath
  always_comb begin
    logic [7:0]  a;
    logic [7:0]  v;
    logic [7:0]  r8;
    logic [15:0] r16;
    logic        z;
    logic        n;
    logic        h;
    logic        c;
    logic        t;
    logic        shz;
    logic [8:0]  sum9;
    logic [4:0]  nib5;
    logic [16:0] sum17;
    logic [12:0] sum13;
    logic [7:0]  adj;
    logic [7:0]  bmask;

    a     = s1_r.acc;
    v     = s1_r.operand;
    z     = s1_r.zero_in;
    n     = s1_r.subtract_in;
    h     = s1_r.half_carry_in;
    c     = s1_r.carry_in;
    t     = 1'b0;
    shz   = 1'b0;
    r8    = 8'h00;
    r16   = 16'h0000;
    sum9  = 9'h000;
    nib5  = 5'h00;
    sum17 = 17'h00000;
    sum13 = 13'h0000;
    adj   = 8'h00;
    bmask = 8'h01 << s1_r.bit_index;

    case (s1_r.req_type)
      OP_ADD, OP_ADC: begin
        t    = (s1_r.req_type == OP_ADC) ? s1_r.carry_in : 1'b0;
        sum9 = {1'b0, a} + {1'b0, v} + {8'h00, t};
        nib5 = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'h0, t};
        r8   = sum9[7:0];
        h    = nib5[4];
        c    = sum9[8];
        n    = 1'b0;
        shz  = 1'b1;
      end
      OP_SUB, OP_SBC, OP_CP: begin
        // borrow shows in the extra top bit
        t    = (s1_r.req_type == OP_SBC) ? s1_r.carry_in : 1'b0;
        sum9 = {1'b0, a} - {1'b0, v} - {8'h00, t};
        nib5 = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'h0, t};
        r8   = sum9[7:0];
        h    = nib5[4];
        c    = sum9[8];
        n    = 1'b1;
        shz  = 1'b1;
      end
      OP_AND: begin
        r8 = a & v; n = 1'b0; h = 1'b1; c = 1'b0; shz = 1'b1;
      end
      OP_XOR: begin
        r8 = a ^ v; n = 1'b0; h = 1'b0; c = 1'b0; shz = 1'b1;
      end
      OP_OR: begin
        r8 = a | v; n = 1'b0; h = 1'b0; c = 1'b0; shz = 1'b1;
      end
      OP_INC8: begin
        r8 = v + 8'd1; h = (v[3:0] == 4'hf); n = 1'b0; shz = 1'b1;
      end
      OP_DEC8: begin
        r8 = v - 8'd1; h = (v[3:0] == 4'h0); n = 1'b1; shz = 1'b1;
      end
      OP_ADD16: begin
        sum17 = {1'b0, s1_r.wide_base} + {1'b0, s1_r.wide_operand};
        sum13 = {1'b0, s1_r.wide_base[11:0]} + {1'b0, s1_r.wide_operand[11:0]};
        r16   = sum17[15:0];
        h     = sum13[12];
        c     = sum17[16];
        n     = 1'b0;
      end
      OP_INC16: r16 = s1_r.wide_operand + 16'd1;
      OP_DEC16: r16 = s1_r.wide_operand - 16'd1;
      OP_SPOFS: begin
        // flags come from the unsigned low byte add
        r16  = s1_r.wide_base + {{8{v[7]}}, v};
        nib5 = {1'b0, s1_r.wide_base[3:0]} + {1'b0, v[3:0]};
        sum9 = {1'b0, s1_r.wide_base[7:0]} + {1'b0, v};
        h    = nib5[4];
        c    = sum9[8];
        z    = 1'b0;
        n    = 1'b0;
      end
      OP_DAA: begin
        if (s1_r.subtract_in) begin
          if (s1_r.half_carry_in) adj = adj | DAA_LO;
          if (s1_r.carry_in) adj = adj | DAA_HI;
          r8 = a - adj;
        end else begin
          if ((a[3:0] > NIB_MAX) || s1_r.half_carry_in) adj = adj | DAA_LO;
          if ((a > BCD_MAX) || s1_r.carry_in) adj = adj | DAA_HI;
          r8 = a + adj;
        end
        c   = |(adj & DAA_HI);
        h   = 1'b0;
        shz = 1'b1;
      end
      OP_CPL: begin
        r8 = ~a; n = 1'b1; h = 1'b1;
      end
      OP_SCF: begin
        r8 = a; n = 1'b0; h = 1'b0; c = 1'b1;
      end
      OP_CCF: begin
        r8 = a; n = 1'b0; h = 1'b0; c = ~s1_r.carry_in;
      end
      // accumulator rotates always clear z
      OP_RLCA: begin
        c = a[7]; r8 = {a[6:0], a[7]}; z = 1'b0; n = 1'b0; h = 1'b0;
      end
      OP_RRCA: begin
        c = a[0]; r8 = {a[0], a[7:1]}; z = 1'b0; n = 1'b0; h = 1'b0;
      end
      OP_RLA: begin
        c = a[7]; r8 = {a[6:0], s1_r.carry_in}; z = 1'b0; n = 1'b0; h = 1'b0;
      end
      OP_RRA: begin
        c = a[0]; r8 = {s1_r.carry_in, a[7:1]}; z = 1'b0; n = 1'b0; h = 1'b0;
      end
      // prefixed rotates and shifts on the operand
      OP_RLC: begin
        c = v[7]; r8 = {v[6:0], v[7]}; n = 1'b0; h = 1'b0; shz = 1'b1;
      end
      OP_RRC: begin
        c = v[0]; r8 = {v[0], v[7:1]}; n = 1'b0; h = 1'b0; shz = 1'b1;
      end
      OP_RL: begin
        c = v[7]; r8 = {v[6:0], s1_r.carry_in}; n = 1'b0; h = 1'b0; shz = 1'b1;
      end
      OP_RR: begin
        c = v[0]; r8 = {s1_r.carry_in, v[7:1]}; n = 1'b0; h = 1'b0; shz = 1'b1;
      end
      OP_SLA: begin
        c = v[7]; r8 = {v[6:0], 1'b0}; n = 1'b0; h = 1'b0; shz = 1'b1;
      end
      OP_SRA: begin
        c = v[0]; r8 = {v[7], v[7:1]}; n = 1'b0; h = 1'b0; shz = 1'b1;
      end
      OP_SWAP: begin
        r8 = {v[3:0], v[7:4]}; n = 1'b0; h = 1'b0; c = 1'b0; shz = 1'b1;
      end
      OP_SRL: begin
        c = v[0]; r8 = {1'b0, v[7:1]}; n = 1'b0; h = 1'b0; shz = 1'b1;
      end
      OP_BIT: begin
        r8 = v; z = ~|(v & bmask); n = 1'b0; h = 1'b1;
      end
      OP_RES: r8 = v & ~bmask;
      OP_SET: r8 = v | bmask;
      default: begin
        // unused codes give zero and keep all flags
        r8 = 8'h00;
      end
    endcase

    if (shz) z = (r8 == 8'h00);

    // compare keeps the accumulator
    if (s1_r.req_type == OP_CP) r8 = a;

    res_nxt.result = (s1_r.req_type == OP_ADD16 || s1_r.req_type == OP_INC16 ||
                      s1_r.req_type == OP_DEC16 || s1_r.req_type == OP_SPOFS)
                     ? r16 : {8'h00, r8};
    res_nxt.zero_out       = z;
    res_nxt.subtract_out   = n;
    res_nxt.half_carry_out = h;
    res_nxt.carry_out      = c;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_en) begin
      out_valid_r <= s1_valid_r;
    end
    if (s2_en && s1_valid_r) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled while pipeline can advance");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> s1_valid_r)
    else $error("transfer in did not reach stage one");

  a_s1_moves_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s2_en) |=> out_valid_r)
    else $error("stage one item lost on advance");

endmodule
